// ===== rtl/intt_pkg.sv =====
// Package with types and constants shared by the inverse NTT engine.
package intt_pkg;

   localparam int CoeffCount = 256;
   localparam int AddrWidth = $clog2(CoeffCount);
   localparam int WordWidth = 23;
   localparam int LayerCount = $clog2(CoeffCount);
   localparam logic [WordWidth-1:0] ModulusReset = 23'd8380417;

   localparam logic [1:0] KIND_WRITE_COEFF = 2'd0;
   localparam logic [1:0] KIND_WRITE_TWIDDLE = 2'd1;
   localparam logic [1:0] KIND_RUN = 2'd2;
   localparam logic [1:0] KIND_READ_COEFF = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] index;
      logic [WordWidth-1:0] value;
   } req_type;

   typedef struct packed {
      logic [WordWidth-1:0] data_out;
      logic transform_done;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic [WordWidth-1:0] a;
      logic [WordWidth-1:0] b;
   } mul_req_type;

endpackage

// ===== rtl/intt_modmul.sv =====
// Sequential modular multiplier: one product bit per cycle, shift-and-add with reduction.
module intt_modmul (
   input  logic clock,
   input  logic reset,
   input  logic [intt_pkg::WordWidth-1:0] modulus,
   input  intt_pkg::mul_req_type mul_req,
   output logic busy,
   output logic [intt_pkg::WordWidth-1:0] product
);

   localparam int W = intt_pkg::WordWidth;

   logic [W-1:0] acc_ff, acc_in;
   logic [W-1:0] mcand_ff, mcand_in;
   logic [W-1:0] mplier_ff, mplier_in;
   logic [$clog2(W+1)-1:0] count_ff, count_in;
   logic busy_ff, busy_in;
   logic [W+1:0] dbl;
   logic [W+1:0] dred;
   logic [W+1:0] sum;
   logic [W+1:0] q;

   assign q = {2'b00, modulus};

   always_comb begin
      acc_in = acc_ff;
      mcand_in = mcand_ff;
      mplier_in = mplier_ff;
      count_in = count_ff;
      busy_in = busy_ff;
      dbl = {1'b0, acc_ff, 1'b0};
      dred = (dbl >= q) ? dbl - q : dbl;
      sum = dred + {2'b00, mcand_ff};
      if (mplier_ff[W-1]) begin
         sum = (sum >= q) ? sum - q : sum;
      end else begin
         sum = dred;
      end
      if (mul_req.start) begin
         acc_in = '0;
         mcand_in = mul_req.a;
         mplier_in = mul_req.b;
         count_in = ($clog2(W+1))'(W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = sum[W-1:0];
         mplier_in = {mplier_ff[W-2:0], 1'b0};
         count_in = count_ff - ($clog2(W+1))'(1);
         if (count_ff == ($clog2(W+1))'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         count_ff <= count_in;
      end
      acc_ff <= acc_in;
      mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign busy = busy_ff;
   assign product = acc_ff;

endmodule

// ===== rtl/inverse_ntt_engine_top.sv =====
// Top level of the inverse NTT engine: memories, sequencer and request channels.
// A transform runs log2(N) layers of Gentleman-Sande butterflies on the
// coefficient memory; every modular product goes through one shared
// bit-serial multiplier. Each twiddle inverse by Fermat exponentiation
// costs up to 2*23+1 products and each butterfly five products. The half
// of two is computed once at the start of each run. Operands are reduced
// modulo the modulus when the transform reads them; a modulus below two
// gives zero for every result.
module inverse_ntt_engine_top (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  intt_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output intt_pkg::rsp_type rsp_data,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [intt_pkg::WordWidth-1:0] csr_data
);

   localparam int W = intt_pkg::WordWidth;
   localparam int A = intt_pkg::AddrWidth;
   localparam int N = intt_pkg::CoeffCount;
   localparam int LW = $clog2(intt_pkg::LayerCount + 1);
   localparam int EW = $clog2(W + 1);

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_READ_WAIT = 5'd1;
   localparam logic [4:0] ST_RESP = 5'd2;
   localparam logic [4:0] ST_INV_INIT = 5'd3;
   localparam logic [4:0] ST_INV_MUL = 5'd4;
   localparam logic [4:0] ST_INV_WAIT = 5'd5;
   localparam logic [4:0] ST_INV_SQR = 5'd6;
   localparam logic [4:0] ST_INV_SQR_WAIT = 5'd7;
   localparam logic [4:0] ST_GROUP = 5'd8;
   localparam logic [4:0] ST_TW_WAIT = 5'd9;
   localparam logic [4:0] ST_BF_READ = 5'd10;
   localparam logic [4:0] ST_BF_WAIT = 5'd11;
   localparam logic [4:0] ST_BF_LOAD = 5'd12;
   localparam logic [4:0] ST_BF_MUL1 = 5'd13;
   localparam logic [4:0] ST_BF_MUL1_WAIT = 5'd14;
   localparam logic [4:0] ST_BF_MUL2 = 5'd15;
   localparam logic [4:0] ST_BF_MUL2_WAIT = 5'd16;
   localparam logic [4:0] ST_BF_MUL3 = 5'd17;
   localparam logic [4:0] ST_BF_MUL3_WAIT = 5'd18;
   localparam logic [4:0] ST_BF_WRITE = 5'd19;
   localparam logic [4:0] ST_HALF_DONE = 5'd20;

   logic [W-1:0] coeff_mem [N];
   logic [W-1:0] twid_mem [N];
   logic [W-1:0] coeff_rd_ff;
   logic [W-1:0] twid_rd_ff;
   logic [A-1:0] coeff_raddr;
   logic coeff_we;
   logic [A-1:0] coeff_waddr;
   logic [W-1:0] coeff_wdata;
   logic twid_we;

   logic [4:0] state_ff, state_in;
   logic [W-1:0] modulus_ff;
   logic [W-1:0] half_ff, half_in;
   logic [W-1:0] zinv_ff, zinv_in;
   logic [W-1:0] base_ff, base_in;
   logic [W-1:0] exp_ff, exp_in;
   logic [EW-1:0] ebit_ff, ebit_in;
   logic inv_half_ff, inv_half_in;
   logic [LW-1:0] layer_ff, layer_in;
   logic [A:0] group_ff, group_in;
   logic [A:0] elem_ff, elem_in;
   logic [A:0] twk_ff, twk_in;
   logic [W-1:0] t_ff, t_in;
   logic [W-1:0] u_ff, u_in;
   logic [W-1:0] lo_ff, lo_in;
   logic [W-1:0] hi_ff, hi_in;
   logic wsel_ff, wsel_in;
   logic [A:0] j_ff, j_in;
   logic rsp_valid_ff, rsp_valid_in;
   intt_pkg::rsp_type rsp_ff, rsp_in;
   logic is_read_ff, is_read_in;

   intt_pkg::mul_req_type mul_req;
   logic mul_busy;
   logic [W-1:0] mul_p;
   logic deg;
   logic [A:0] span;
   logic [A:0] j_cur;
   logic [A:0] m_cur;
   logic [W-1:0] rt, ru;
   logic [W:0] s_wide;
   logic [W:0] d_wide;
   logic [W-1:0] sum_mod, dif_mod;

   function automatic logic [W-1:0] reduce(input logic [W-1:0] x, input logic [W-1:0] q);
      logic [W-1:0] r;
      r = x;
      if (x >= q) begin
         r = x - q;
      end
      return r;
   endfunction

   intt_modmul u_modmul (
      .clock(clock),
      .reset(reset),
      .modulus(modulus_ff),
      .mul_req(mul_req),
      .busy(mul_busy),
      .product(mul_p)
   );

   assign deg = modulus_ff < W'(2);
   assign span = (A+1)'(1) << layer_ff;
   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // Stored words can exceed the modulus by more than one multiple; reduce via multiply by one.
   // A single conditional subtract suffices only when the word is below twice the modulus,
   // so operands are canonicalized by the multiplier instead (see loads below).
   assign rt = t_ff;
   assign ru = u_ff;
   assign s_wide = {1'b0, rt} + {1'b0, ru};
   assign d_wide = {1'b0, rt} + {1'b0, modulus_ff} - {1'b0, ru};
   assign sum_mod = (s_wide >= {1'b0, modulus_ff}) ? W'(s_wide - {1'b0, modulus_ff})
                                                   : s_wide[W-1:0];
   assign dif_mod = (d_wide >= {1'b0, modulus_ff}) ? W'(d_wide - {1'b0, modulus_ff})
                                                   : d_wide[W-1:0];

   assign j_cur = j_ff;
   assign m_cur = j_ff + span;

   always_comb begin
      state_in = state_ff;
      half_in = half_ff;
      zinv_in = zinv_ff;
      base_in = base_ff;
      exp_in = exp_ff;
      ebit_in = ebit_ff;
      inv_half_in = inv_half_ff;
      layer_in = layer_ff;
      group_in = group_ff;
      elem_in = elem_ff;
      twk_in = twk_ff;
      t_in = t_ff;
      u_in = u_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      wsel_in = wsel_ff;
      j_in = j_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      is_read_in = is_read_ff;
      mul_req = '0;
      coeff_raddr = req_data.index[A-1:0];
      coeff_we = 1'b0;
      coeff_waddr = req_data.index[A-1:0];
      coeff_wdata = req_data.value;
      twid_we = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               is_read_in = 1'b0;
               unique case (req_data.kind)
                  intt_pkg::KIND_WRITE_COEFF: begin
                     coeff_we = (req_data.index < 8'(N - 1) + 8'd1) || (N > 255);
                     rsp_in = '0;
                     state_in = ST_RESP;
                  end
                  intt_pkg::KIND_WRITE_TWIDDLE: begin
                     twid_we = (req_data.index < 8'(N - 1) + 8'd1) || (N > 255);
                     rsp_in = '0;
                     state_in = ST_RESP;
                  end
                  intt_pkg::KIND_READ_COEFF: begin
                     is_read_in = (req_data.index < 8'(N - 1) + 8'd1) || (N > 255);
                     state_in = ST_READ_WAIT;
                  end
                  intt_pkg::KIND_RUN: begin
                     inv_half_in = 1'b1;
                     base_in = W'(2);
                     state_in = ST_INV_INIT;
                  end
               endcase
            end
         end
         ST_READ_WAIT: begin
            state_in = ST_RESP;
            rsp_in.transform_done = 1'b0;
            rsp_in.data_out = is_read_ff ? coeff_rd_ff : '0;
         end
         ST_RESP: begin
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         ST_INV_INIT: begin
            // base_ff holds the raw value; reduce it by multiplying with one.
            exp_in = modulus_ff - W'(2);
            ebit_in = '0;
            zinv_in = reduce(W'(1), modulus_ff);
            mul_req.start = 1'b1;
            mul_req.a = reduce(W'(1), modulus_ff);
            mul_req.b = base_ff;
            state_in = ST_INV_SQR_WAIT;
         end
         ST_INV_MUL: begin
            if (ebit_ff == EW'(W)) begin
               if (inv_half_ff) begin
                  half_in = deg ? '0 : zinv_ff;
                  inv_half_in = 1'b0;
                  layer_in = '0;
                  group_in = (A+1)'(N / 2);
                  twk_in = (A+1)'(N);
                  state_in = ST_GROUP;
               end else begin
                  if (deg) begin
                     zinv_in = '0;
                  end
                  elem_in = span;
                  state_in = ST_BF_READ;
               end
            end else if (exp_ff[0]) begin
               mul_req.start = 1'b1;
               mul_req.a = zinv_ff;
               mul_req.b = base_ff;
               state_in = ST_INV_WAIT;
            end else begin
               state_in = ST_INV_SQR;
            end
         end
         ST_INV_WAIT: begin
            if (!mul_busy) begin
               zinv_in = mul_p;
               state_in = ST_INV_SQR;
            end
         end
         ST_INV_SQR: begin
            mul_req.start = 1'b1;
            mul_req.a = base_ff;
            mul_req.b = base_ff;
            ebit_in = ebit_ff + EW'(1);
            exp_in = exp_ff >> 1;
            state_in = ST_INV_SQR_WAIT;
         end
         ST_INV_SQR_WAIT: begin
            if (!mul_busy && !mul_req.start) begin
               base_in = mul_p;
               state_in = ST_INV_MUL;
            end
         end
         ST_GROUP: begin
            if (layer_ff == LW'(intt_pkg::LayerCount)) begin
               rsp_in = '0;
               rsp_in.transform_done = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end else if (group_ff == '0) begin
               layer_in = layer_ff + LW'(1);
               group_in = (A+1)'(N) >> (layer_ff + LW'(2));
            end else begin
               if (twk_ff != '0) begin
                  twk_in = twk_ff - (A+1)'(1);
               end
               state_in = ST_TW_WAIT;
            end
         end
         ST_TW_WAIT: begin
            base_in = twid_rd_ff;
            state_in = ST_INV_INIT;
         end
         ST_BF_READ: begin
            if (elem_ff == '0) begin
               group_in = group_ff - (A+1)'(1);
               state_in = ST_GROUP;
            end else begin
               j_in = (group_ff - (A+1)'(1)) * (span << 1) + elem_ff - (A+1)'(1);
               elem_in = elem_ff - (A+1)'(1);
               state_in = ST_BF_WAIT;
            end
         end
         ST_BF_WAIT: begin
            coeff_raddr = j_cur[A-1:0];
            wsel_in = 1'b0;
            state_in = ST_BF_LOAD;
         end
         ST_BF_LOAD: begin
            coeff_raddr = m_cur[A-1:0];
            if (!wsel_ff) begin
               t_in = coeff_rd_ff;
               wsel_in = 1'b1;
            end else begin
               u_in = coeff_rd_ff;
               mul_req.start = 1'b1;
               mul_req.a = reduce(W'(1), modulus_ff);
               mul_req.b = t_ff;
               state_in = ST_BF_MUL1;
            end
         end
         ST_BF_MUL1: begin
            if (!mul_busy) begin
               t_in = deg ? '0 : mul_p;
               mul_req.start = 1'b1;
               mul_req.a = reduce(W'(1), modulus_ff);
               mul_req.b = u_ff;
               state_in = ST_BF_MUL1_WAIT;
            end
         end
         ST_BF_MUL1_WAIT: begin
            if (!mul_busy) begin
               u_in = deg ? '0 : mul_p;
               state_in = ST_BF_MUL2;
            end
         end
         ST_BF_MUL2: begin
            mul_req.start = 1'b1;
            mul_req.a = half_ff;
            mul_req.b = sum_mod;
            lo_in = dif_mod;
            state_in = ST_BF_MUL2_WAIT;
         end
         ST_BF_MUL2_WAIT: begin
            if (!mul_busy) begin
               hi_in = mul_p;
               mul_req.start = 1'b1;
               mul_req.a = zinv_ff;
               mul_req.b = lo_ff;
               state_in = ST_BF_MUL3;
            end
         end
         ST_BF_MUL3: begin
            if (!mul_busy && !mul_req.start) begin
               mul_req.start = 1'b1;
               mul_req.a = half_ff;
               mul_req.b = mul_p;
               state_in = ST_BF_MUL3_WAIT;
            end
         end
         ST_BF_MUL3_WAIT: begin
            if (!mul_busy) begin
               lo_in = mul_p;
               coeff_we = 1'b1;
               coeff_waddr = j_cur[A-1:0];
               coeff_wdata = deg ? '0 : hi_ff;
               state_in = ST_BF_WRITE;
            end
         end
         ST_BF_WRITE: begin
            coeff_we = 1'b1;
            coeff_waddr = m_cur[A-1:0];
            coeff_wdata = deg ? '0 : lo_ff;
            state_in = ST_BF_READ;
         end
         ST_HALF_DONE: begin
            state_in = ST_GROUP;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (coeff_we) begin
         coeff_mem[coeff_waddr] <= coeff_wdata;
      end
      coeff_rd_ff <= coeff_mem[coeff_raddr];
   end

   always_ff @(posedge clock) begin
      if (twid_we) begin
         twid_mem[req_data.index[A-1:0]] <= req_data.value;
      end
      twid_rd_ff <= twid_mem[twk_in[A-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         modulus_ff <= intt_pkg::ModulusReset;
         rsp_valid_ff <= 1'b0;
         inv_half_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         inv_half_ff <= inv_half_in;
         if (csr_valid && csr_ready) begin
            modulus_ff <= csr_data;
         end
      end
      half_ff <= half_in;
      zinv_ff <= zinv_in;
      base_ff <= base_in;
      exp_ff <= exp_in;
      ebit_ff <= ebit_in;
      layer_ff <= layer_in;
      group_ff <= group_in;
      elem_ff <= elem_in;
      twk_ff <= twk_in;
      t_ff <= t_in;
      u_ff <= u_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      wsel_ff <= wsel_in;
      j_ff <= j_in;
      rsp_ff <= rsp_in;
      is_read_ff <= is_read_in;
   end

endmodule

// ===== test/inverse_ntt_engine_top_tb.sv =====
// Testbench for the inverse NTT engine: loads, transform runs and read-back, checked against a predictor.
module inverse_ntt_engine_top_tb;

   localparam int WordWidth = intt_pkg::WordWidth;
   localparam int CoeffCount = intt_pkg::CoeffCount;

   typedef struct {
      intt_pkg::req_type r;
      intt_pkg::rsp_type e;
   } directed_row_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   intt_pkg::req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   intt_pkg::rsp_type rsp_data;
   logic csr_valid;
   logic csr_ready;
   logic [WordWidth-1:0] csr_data;

   logic [WordWidth-1:0] modulus_q;
   logic [WordWidth-1:0] coeff_mem [CoeffCount];
   logic [WordWidth-1:0] twiddle_mem [CoeffCount];
   intt_pkg::rsp_type pending_rsp [$];
   int mismatch_count;
   bit quiet;

   inverse_ntt_engine_top dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2000000000;
      $display("inverse_ntt_engine_top test failed");
      $finish;
   end

   function automatic longint unsigned mod_reduce(longint unsigned x);
      if (modulus_q < 2) return 0;
      return x % modulus_q;
   endfunction

   function automatic longint unsigned mod_mul(longint unsigned a, longint unsigned b);
      return mod_reduce(mod_reduce(a) * mod_reduce(b));
   endfunction

   function automatic longint unsigned mod_inverse(longint unsigned x);
      longint unsigned e;
      longint unsigned b;
      longint unsigned acc;
      if (modulus_q < 2) return 0;
      e = modulus_q - 2;
      b = mod_reduce(x);
      acc = mod_reduce(1);
      while (e != 0) begin
         if (e[0]) acc = mod_mul(acc, b);
         b = mod_mul(b, b);
         e = e >> 1;
      end
      return acc;
   endfunction

   function automatic void inverse_transform();
      longint unsigned half;
      longint unsigned zinv;
      longint unsigned t;
      longint unsigned u;
      longint unsigned sum;
      longint unsigned diff;
      int groups;
      int k;
      int base;
      int j;
      int m;
      half = mod_inverse(2);
      groups = CoeffCount;
      k = CoeffCount;
      for (int span = 1; span < CoeffCount; span *= 2) begin
         for (int g = groups / 2; g > 0; g--) begin
            base = (g - 1) * 2 * span;
            k--;
            zinv = mod_inverse(twiddle_mem[k]);
            for (int i = span; i > 0; i--) begin
               j = base + i - 1;
               m = j + span;
               t = coeff_mem[j];
               u = coeff_mem[m];
               sum = mod_reduce(mod_reduce(t) + mod_reduce(u));
               diff = mod_reduce(mod_reduce(t) + modulus_q - mod_reduce(u));
               coeff_mem[j] = WordWidth'(mod_mul(half, sum));
               coeff_mem[m] = WordWidth'(mod_mul(half, mod_mul(zinv, diff)));
            end
         end
         groups /= 2;
      end
   endfunction

   function automatic intt_pkg::rsp_type predict_response(intt_pkg::req_type r);
      intt_pkg::rsp_type p;
      p = '0;
      case (r.kind)
         intt_pkg::KIND_WRITE_COEFF: coeff_mem[r.index] = r.value;
         intt_pkg::KIND_WRITE_TWIDDLE: twiddle_mem[r.index] = r.value;
         intt_pkg::KIND_RUN: begin
            inverse_transform();
            p.transform_done = 1'b1;
         end
         default: p.data_out = coeff_mem[r.index];
      endcase
      return p;
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   task automatic send_request(intt_pkg::req_type r, bit typed, intt_pkg::rsp_type typed_rsp);
      int gap;
      intt_pkg::rsp_type p;
      gap = quiet ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      p = predict_response(r);
      pending_rsp.push_back(typed ? typed_rsp : p);
   endtask

   task automatic send_item(logic [1:0] kind, int idx, logic [WordWidth-1:0] value);
      intt_pkg::req_type r;
      r.kind = kind;
      r.index = idx[7:0];
      r.value = value;
      send_request(r, 1'b0, '0);
   endtask

   task automatic drain_responses();
      @(negedge clock) req_valid <= 1'b0;
      wait (pending_rsp.size() == 0);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_modulus(logic [WordWidth-1:0] q);
      drain_responses();
      csr_valid <= 1'b1;
      csr_data <= q;
      do @(posedge clock); while (!csr_ready);
      modulus_q = q;
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   function automatic logic [WordWidth-1:0] random_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return WordWidth'($urandom);
      endcase
   endfunction

   task automatic load_and_run();
      for (int i = 0; i < CoeffCount; i++) begin
         send_item(intt_pkg::KIND_WRITE_COEFF, i, random_word());
         send_item(intt_pkg::KIND_WRITE_TWIDDLE, i, random_word());
      end
      drain_responses();
      send_item(intt_pkg::KIND_RUN, $urandom_range(0, 255), WordWidth'($urandom));
      for (int i = 0; i < 40; i++) send_item(intt_pkg::KIND_READ_COEFF, i * 6 + 15, '0);
   endtask

   task automatic random_mix(int count);
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: send_item(intt_pkg::KIND_READ_COEFF, $urandom_range(0, 255),
               WordWidth'($urandom));
            6, 7: send_item(intt_pkg::KIND_WRITE_COEFF, $urandom_range(0, 255),
               random_word());
            default: send_item(intt_pkg::KIND_WRITE_TWIDDLE, $urandom_range(0, 255),
               random_word());
         endcase
      end
   endtask

   initial begin
      int stall;
      rsp_ready = 1'b0;
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            @(negedge clock) rsp_ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock) rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   always @(posedge clock) begin
      intt_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("response with none expected");
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.data_out !== want.data_out)
               report_mismatch($sformatf("data_out %0h, expected %0h",
                  rsp_data.data_out, want.data_out));
            if (rsp_data.transform_done !== want.transform_done)
               report_mismatch($sformatf("transform_done %0b, expected %0b",
                  rsp_data.transform_done, want.transform_done));
         end
      end
   end

   initial begin
      directed_row_type rows [$];
      rows = '{
         '{'{intt_pkg::KIND_WRITE_COEFF, 8'd0, 23'd0}, '{23'd0, 1'b0}},
         '{'{intt_pkg::KIND_READ_COEFF, 8'd0, 23'h7FFFFF}, '{23'd0, 1'b0}},
         '{'{intt_pkg::KIND_WRITE_COEFF, 8'd0, 23'h7FFFFF}, '{23'd0, 1'b0}},
         '{'{intt_pkg::KIND_READ_COEFF, 8'd0, 23'd0}, '{23'h7FFFFF, 1'b0}},
         '{'{intt_pkg::KIND_WRITE_COEFF, 8'd255, 23'd8380417}, '{23'd0, 1'b0}},
         '{'{intt_pkg::KIND_READ_COEFF, 8'd255, 23'd0}, '{23'd8380417, 1'b0}},
         '{'{intt_pkg::KIND_WRITE_TWIDDLE, 8'd255, 23'h7FFFFF}, '{23'd0, 1'b0}},
         '{'{intt_pkg::KIND_WRITE_TWIDDLE, 8'd0, 23'd0}, '{23'd0, 1'b0}},
         '{'{intt_pkg::KIND_WRITE_COEFF, 8'd170, 23'h2AAAAA}, '{23'd0, 1'b0}},
         '{'{intt_pkg::KIND_READ_COEFF, 8'd170, 23'h555555}, '{23'h2AAAAA, 1'b0}},
         '{'{intt_pkg::KIND_WRITE_COEFF, 8'd85, 23'h555555}, '{23'd0, 1'b0}},
         '{'{intt_pkg::KIND_READ_COEFF, 8'd85, 23'h2AAAAA}, '{23'h555555, 1'b0}}
      };
      mismatch_count = 0;
      quiet = 1'b0;
      modulus_q = intt_pkg::ModulusReset;
      for (int i = 0; i < CoeffCount; i++) begin
         coeff_mem[i] = '0;
         twiddle_mem[i] = '0;
      end
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      foreach (rows[i]) send_request(rows[i].r, 1'b1, rows[i].e);
      load_and_run();
      random_mix(60);

      write_modulus(23'd3);
      quiet = 1'b1;
      load_and_run();
      random_mix(40);
      quiet = 1'b0;

      write_modulus(23'h7FFFFF);
      load_and_run();
      random_mix(40);

      write_modulus(WordWidth'($urandom_range(3, 8388607)));
      random_mix(60);

      drain_responses();
      repeat (50) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("inverse_ntt_engine_top test passed");
      end else begin
         $display("inverse_ntt_engine_top test failed");
      end
      $finish;
   end

endmodule
